FILE: src/assert_macros.svh
// Assertion macros used by the checker module of the hash key/value table.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define HKV_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define HKV_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/hkv_pkg.sv
// Shared types, codes and default sizes of the hash key/value table.
// Depends on nothing; imported by every module of the block but hkv_ram.
`timescale 1ns / 1ps
`default_nettype none

package hkv_pkg;

  localparam int KEY_W = 20;
  localparam int VAL_W = 31;

  localparam int DEF_BUCKETS = 1024;
  localparam int DEF_WAYS    = 4;

  localparam logic [1:0] MODE_PUT    = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] data_out;
  } res_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic rd;
    logic exec;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/hash_key_value_table_top.sv
// Top level of the hash key/value table: controller plus datapath.
// Depends on hkv_pkg, hkv_ctrl, hkv_dp and hkv_ram.
//
// Usage:
//   Input channel: drive in_req (mode, key, data_in) and raise start; the
//   transaction is taken at the rising edge where start is high and busy low.
//   Modes: put stores or overwrites, get looks up, remove frees the way.
//   Result channel: out_valid is high for exactly one cycle with out_res
//   (status, data_out); the receiver cannot stall and must take it then.
//   Every transaction yields exactly one result.
//   The sequencer takes one transaction at a time and keeps busy high until
//   its result is out: two multiplier steps for key mod BUCKETS, one
//   bucket-row read of the RAM and one compare and write-back of that row.
//   Reset: rst_n is synchronous, active low. After reset the block clears
//   the valid bits of all BUCKETS rows of the bucket RAM, one row a cycle, and
//   keeps busy high until that pass ends.
`timescale 1ns / 1ps
`default_nettype none

module hash_key_value_table_top
  import hkv_pkg::*;
#(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int WAYS    = DEF_WAYS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire req_t in_req,
  output logic      out_valid,
  output res_t      out_res
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  hkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  hkv_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .stat    (stat),
    .out_res (out_res)
  );

endmodule

`default_nettype wire

FILE: src/hkv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module hkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/hkv_ctrl.sv
// Controller state machine of the hash key/value table: clear pass, hash, lookup, commit.
// Depends on hkv_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hkv_ctrl
  import hkv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire dp_stat_t   stat,
  output logic            busy,
  output logic            out_valid,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL1  = 6'b000100,
    S_MUL2  = 6'b001000,
    S_MOD   = 6'b010000,
    S_EXEC  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (stat.clear_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_MOD;
      S_MOD:   state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    cmd.load  = (state_r == S_IDLE) && start;
    cmd.mul1  = (state_r == S_MUL1);
    cmd.mul2  = (state_r == S_MUL2);
    cmd.rd    = (state_r == S_MOD);
    cmd.exec  = (state_r == S_EXEC);
    cmd.clear = (state_r == S_CLEAR);
  end

endmodule

`default_nettype wire

FILE: src/hkv_dp.sv
// Datapath of the hash key/value table: bucket hash, bucket RAM, match and update of one row.
// Depends on hkv_pkg and hkv_ram.
`timescale 1ns / 1ps
`default_nettype none

module hkv_dp
  import hkv_pkg::*;
#(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int WAYS    = DEF_WAYS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ctrl_cmd_t  cmd,
  input  wire req_t       in_req,
  output dp_stat_t        stat,
  output res_t            out_res
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int BCW   = $clog2(BUCKETS + 1);
  localparam int QBW   = KEY_W + BCW;
  localparam int PW    = KEY_W + 32;
  localparam int ROW_W = WAYS * (1 + KEY_W + VAL_W);
  localparam longint unsigned RECIP_L = (64'd1 << 32) / BUCKETS;
  localparam logic [31:0] RECIP = 32'(RECIP_L);

  req_t             req_r;
  logic [PW-1:0]    prod1_r;
  logic [KEY_W-1:0] qb_r;
  logic [BW-1:0]    bucket_r;
  logic [BW-1:0]    clr_addr_r;
  res_t             res_r;

  logic [QBW-1:0]   qb_full;
  logic [KEY_W-1:0] diff;
  logic [KEY_W-1:0] rem;
  logic [BW-1:0]    bucket;

  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  logic             ram_we;
  logic [BW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata;

  logic [WAYS-1:0]             row_valid, nxt_valid;
  logic [WAYS-1:0][KEY_W-1:0]  row_key, nxt_key;
  logic [WAYS-1:0][VAL_W-1:0]  row_val, nxt_val;
  logic [WAYS-1:0]             hit, hit_oh, free, free_oh;
  logic [VAL_W-1:0]            hit_val;
  logic                        row_dirty;
  res_t                        res_nxt;

  assign qb_full = QBW'(prod1_r[PW-1:32]) * QBW'(BUCKETS);
  assign diff    = req_r.key - qb_r;
  assign rem     = (diff >= KEY_W'(BUCKETS)) ? (diff - KEY_W'(BUCKETS)) : diff;
  assign bucket  = rem[BW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.mul1) begin
      prod1_r <= PW'(req_r.key) * PW'(RECIP);
    end
    if (cmd.mul2) begin
      qb_r <= qb_full[KEY_W-1:0];
    end
    if (cmd.rd) begin
      bucket_r <= bucket;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear) begin
      clr_addr_r <= clr_addr_r + BW'(1);
    end
  end

  assign stat.clear_last = (clr_addr_r == BW'(BUCKETS - 1));

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_valid[w] = rd_row[w];
      row_key[w]   = rd_row[WAYS + w*KEY_W +: KEY_W];
      row_val[w]   = rd_row[WAYS + WAYS*KEY_W + w*VAL_W +: VAL_W];
      hit[w]       = row_valid[w] && (row_key[w] == req_r.key);
    end
    free    = ~row_valid;
    hit_oh  = hit & ~(hit - WAYS'(1));
    free_oh = free & ~(free - WAYS'(1));
    hit_val = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) begin
        hit_val = hit_val | row_val[w];
      end
    end
  end

  always_comb begin
    nxt_valid        = row_valid;
    nxt_key          = row_key;
    nxt_val          = row_val;
    row_dirty        = 1'b0;
    res_nxt.status   = STAT_NOT_FOUND;
    res_nxt.data_out = '0;
    unique case (req_r.mode)
      MODE_PUT: begin
        if (|hit) begin
          for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) nxt_val[w] = req_r.data_in;
          end
          row_dirty      = 1'b1;
          res_nxt.status = STAT_OK;
        end else if (|free) begin
          for (int w = 0; w < WAYS; w++) begin
            if (free_oh[w]) begin
              nxt_valid[w] = 1'b1;
              nxt_key[w]   = req_r.key;
              nxt_val[w]   = req_r.data_in;
            end
          end
          row_dirty      = 1'b1;
          res_nxt.status = STAT_OK;
        end else begin
          res_nxt.status = STAT_FULL;
        end
      end
      MODE_GET: begin
        if (|hit) begin
          res_nxt.status   = STAT_OK;
          res_nxt.data_out = hit_val;
        end
      end
      MODE_REMOVE: begin
        if (|hit) begin
          nxt_valid      = row_valid & ~hit_oh;
          row_dirty      = 1'b1;
          res_nxt.status = STAT_OK;
        end
      end
      default: begin
        res_nxt.status = STAT_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    wr_row[WAYS-1:0] = nxt_valid;
    for (int w = 0; w < WAYS; w++) begin
      wr_row[WAYS + w*KEY_W +: KEY_W]               = nxt_key[w];
      wr_row[WAYS + WAYS*KEY_W + w*VAL_W +: VAL_W] = nxt_val[w];
    end
  end

  assign ram_we    = cmd.clear || (cmd.exec && row_dirty);
  assign ram_waddr = cmd.clear ? clr_addr_r : bucket_r;
  assign ram_wdata = cmd.clear ? '0 : wr_row;

  hkv_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (bucket),
    .rdata (rd_row)
  );

  assign out_res = res_r;

endmodule

`default_nettype wire

FILE: src/hkv_checker.sv
// Port-level checks of the hash key/value table, bound to the top level.
// Depends on hkv_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hkv_checker
  import hkv_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire res_t out_res
);

  logic status_known;
  logic status_miss;

  assign status_known = (out_res.status == STAT_OK) || (out_res.status == STAT_NOT_FOUND) ||
                        (out_res.status == STAT_FULL);
  assign status_miss  = (out_res.status != STAT_OK);

  `HKV_ASSERT_RST(a_strobe_single, clk, rst_n, out_valid |=> !out_valid, "result strobe held")
  `HKV_ASSERT_RST(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accept without busy")
  `HKV_ASSERT_RST(a_status_code, clk, rst_n, out_valid |-> status_known, "bad status")
  `HKV_ASSERT_RST(a_data_zero, clk, rst_n, (out_valid && status_miss) |-> !(|out_res.data_out), "data on miss")
  `HKV_ASSERT_ALL(a_reset_clear, clk, !rst_n |=> busy, "no clear pass after reset")

endmodule

bind hash_key_value_table_top hkv_checker u_hkv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

`default_nettype wire
